// ===== hw/rtl/ljpf_pkg.sv =====
// Shared types and constants for the Lennard-Jones pair force pipeline.
package ljpf_pkg;

   localparam logic [1:0] CUT_NONE  = 2'd0;
   localparam logic [1:0] CUT_SIGMA = 2'd1;
   localparam logic [1:0] CUT_FIXED = 2'd2;

   localparam logic REG_CUTOFF_MODE      = 1'b0;
   localparam logic REG_CUTOFF_RADIUS_SQ = 1'b1;

   // 2^(1/3) in Q1.31
   localparam logic [31:0] CBRT2_Q31 = 32'd2705659852;
   // 0.5 in Q16
   localparam logic [51:0] T_HALF = 52'd32768;

   localparam int Q1W = 28;
   localparam int Q2W = 63;

   typedef struct packed {
      logic signed [31:0] dx;
      logic signed [31:0] dy;
      logic signed [31:0] dz;
      logic [23:0]        root_eps_first;
      logic [23:0]        root_eps_second;
      logic [23:0]        sigma_first;
      logic [23:0]        sigma_second;
   } req_type;

   typedef struct packed {
      logic signed [31:0] fx;
      logic signed [31:0] fy;
      logic signed [31:0] fz;
      logic               beyond_cutoff;
      logic               zero_distance;
      logic               saturated;
   } rsp_type;

   // per-item side data that rides along the pipeline
   typedef struct packed {
      logic [2:0][31:0] dm;
      logic [2:0]       dneg;
      logic [53:0]      e48;
      logic [63:0]      r2;
      logic             zero;
      logic             beyond;
      logic             huge1;
      logic             eps_nz;
      logic             tneg;
      logic             huge2;
   } ctx_type;

endpackage

// ===== hw/rtl/ljpf_div_step.sv =====
// One restoring division step against a 64-bit divisor.
module ljpf_div_step (
   input  logic [63:0] rem_i,
   input  logic        bit_i,
   input  logic [63:0] div_i,
   output logic [63:0] rem_o,
   output logic        q_o
);

   logic [64:0] trial;
   logic [65:0] diff;

   assign trial = {rem_i, bit_i};
   assign diff  = {1'b0, trial} - {2'b00, div_i};
   assign q_o   = ~diff[65];
   assign rem_o = q_o ? diff[63:0] : trial[63:0];

endmodule

// ===== hw/rtl/ljpf_front.sv =====
// Front stages: magnitudes, squared distance, epsilon, sigma squared and cutoff test.
module ljpf_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  ljpf_pkg::req_type   in_item,
   input  logic [1:0]          cutoff_mode,
   input  logic [31:0]         cutoff_radius_sq,
   output logic                out_valid,
   output ljpf_pkg::ctx_type   out_ctx,
   output logic [49:0]         out_sig2
);

   logic [4:0] vld_ff;

   logic [2:0][31:0] f1_dm_ff, f1_dm_in;
   logic [2:0]       f1_dneg_ff;
   logic [47:0]      f1_eps_ff;
   logic [24:0]      f1_ssum_ff;

   logic [2:0][31:0] f2_dm_ff;
   logic [2:0]       f2_dneg_ff;
   logic [2:0][63:0] f2_sq_ff;
   logic [49:0]      f2_sig2_ff;
   logic [53:0]      f2_e48_ff;

   logic [2:0][31:0] f3_dm_ff;
   logic [2:0]       f3_dneg_ff;
   logic [63:0]      f3_r2_ff;
   logic [49:0]      f3_sig2_ff;
   logic [53:0]      f3_e48_ff;
   logic [63:0]      f3_pl_ff;
   logic [49:0]      f3_ph_ff;

   logic [2:0][31:0] f4_dm_ff;
   logic [2:0]       f4_dneg_ff;
   logic [63:0]      f4_r2_ff;
   logic [49:0]      f4_sig2_ff;
   logic [53:0]      f4_e48_ff;
   logic [63:0]      f4_rc2_ff, f4_rc2_in;
   logic [81:0]      cut_prod;

   ljpf_pkg::ctx_type f5_ctx_ff;
   logic [49:0]       f5_sig2_ff;

   always_comb begin
      f1_dm_in[0] = in_item.dx[31] ? (32'd0 - $unsigned(in_item.dx)) : $unsigned(in_item.dx);
      f1_dm_in[1] = in_item.dy[31] ? (32'd0 - $unsigned(in_item.dy)) : $unsigned(in_item.dy);
      f1_dm_in[2] = in_item.dz[31] ? (32'd0 - $unsigned(in_item.dz)) : $unsigned(in_item.dz);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[3:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      f1_dm_ff   <= f1_dm_in;
      f1_dneg_ff <= {in_item.dz[31], in_item.dy[31], in_item.dx[31]};
      f1_eps_ff  <= 48'(in_item.root_eps_first) * 48'(in_item.root_eps_second);
      f1_ssum_ff <= 25'(in_item.sigma_first) + 25'(in_item.sigma_second);
   end

   always_ff @(posedge clock) begin
      f2_dm_ff   <= f1_dm_ff;
      f2_dneg_ff <= f1_dneg_ff;
      for (int i = 0; i < 3; i++) begin
         f2_sq_ff[i] <= 64'(f1_dm_ff[i]) * 64'(f1_dm_ff[i]);
      end
      f2_sig2_ff <= 50'(f1_ssum_ff) * 50'(f1_ssum_ff);
      f2_e48_ff  <= 54'({f1_eps_ff, 5'b0}) + 54'({f1_eps_ff, 4'b0});
   end

   always_ff @(posedge clock) begin
      f3_dm_ff   <= f2_dm_ff;
      f3_dneg_ff <= f2_dneg_ff;
      f3_r2_ff   <= f2_sq_ff[0] + f2_sq_ff[1] + f2_sq_ff[2];
      f3_sig2_ff <= f2_sig2_ff;
      f3_e48_ff  <= f2_e48_ff;
      f3_pl_ff   <= 64'(f2_sig2_ff[31:0]) * 64'(ljpf_pkg::CBRT2_Q31);
      f3_ph_ff   <= 50'(f2_sig2_ff[49:32]) * 50'(ljpf_pkg::CBRT2_Q31);
   end

   assign cut_prod = {f3_ph_ff, 32'b0} + 82'(f3_pl_ff);

   always_comb begin
      unique case (cutoff_mode)
         ljpf_pkg::CUT_SIGMA: f4_rc2_in = 64'(cut_prod[81:33]);
         ljpf_pkg::CUT_FIXED: f4_rc2_in = {16'b0, cutoff_radius_sq, 16'b0};
         ljpf_pkg::CUT_NONE:  f4_rc2_in = '0;
         default:             f4_rc2_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      f4_dm_ff   <= f3_dm_ff;
      f4_dneg_ff <= f3_dneg_ff;
      f4_r2_ff   <= f3_r2_ff;
      f4_sig2_ff <= f3_sig2_ff;
      f4_e48_ff  <= f3_e48_ff;
      f4_rc2_ff  <= f4_rc2_in;
   end

   always_ff @(posedge clock) begin
      f5_ctx_ff.dm     <= f4_dm_ff;
      f5_ctx_ff.dneg   <= f4_dneg_ff;
      f5_ctx_ff.e48    <= f4_e48_ff;
      f5_ctx_ff.r2     <= f4_r2_ff;
      f5_ctx_ff.zero   <= (f4_r2_ff == 64'd0);
      f5_ctx_ff.beyond <= (f4_rc2_ff != 64'd0) && (f4_r2_ff > f4_rc2_ff);
      // quotient sigma^2/r2 would reach 2^28 in Q16
      f5_ctx_ff.huge1  <= {28'b0, f4_sig2_ff} >= {f4_r2_ff, 14'b0};
      f5_ctx_ff.eps_nz <= (f4_e48_ff != 54'd0);
      f5_ctx_ff.tneg   <= 1'b0;
      f5_ctx_ff.huge2  <= 1'b0;
      f5_sig2_ff       <= f4_sig2_ff;
   end

   assign out_valid = vld_ff[4];
   assign out_ctx   = f5_ctx_ff;
   assign out_sig2  = f5_sig2_ff;

endmodule

// ===== hw/rtl/lennard_jones_pair_force_unit.sv =====
// Top level of the Lennard-Jones pair force pipeline.
//
// Usage: drive req_data and pulse start; an item is taken at every edge
// where start is high and busy is low. busy is always low, so a new pair
// may enter in every cycle.
// Each item gives one result: rsp_data is valid for the single cycle in
// which rsp_strobe is high.
// The receiver cannot hold results off; the pipeline never stalls.
// The two pipelined restoring dividers take 28 steps for
// sigma^2/r2 and 63 steps for the force coefficient, one step per stage,
// with 17 stages of multiply, add and compare around them.
// Throughput: one item per cycle.
// The csr channel writes cutoff_mode (index 0) and cutoff_radius_sq
// (index 1); csr_ready is always high. Write it only while no item is in
// flight. Reset clears the registers (no cutoff) and empties the pipeline.
module lennard_jones_pair_force_unit (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  ljpf_pkg::req_type   req_data,
   output logic                rsp_strobe,
   output ljpf_pkg::rsp_type   rsp_data,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic                csr_index,
   input  logic [31:0]         csr_data
);

   localparam int Q1W = ljpf_pkg::Q1W;
   localparam int Q2W = ljpf_pkg::Q2W;

   logic [1:0]  cutoff_mode_ff;
   logic [31:0] cutoff_radius_sq_ff;

   logic              fr_valid;
   ljpf_pkg::ctx_type fr_ctx;
   logic [49:0]       fr_sig2;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cutoff_mode_ff      <= ljpf_pkg::CUT_NONE;
         cutoff_radius_sq_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            ljpf_pkg::REG_CUTOFF_MODE:      cutoff_mode_ff      <= csr_data[1:0];
            ljpf_pkg::REG_CUTOFF_RADIUS_SQ: cutoff_radius_sq_ff <= csr_data;
         endcase
      end
   end

   ljpf_front u_front (
      .clock            (clock),
      .reset            (reset),
      .in_valid         (start & ~busy),
      .in_item          (req_data),
      .cutoff_mode      (cutoff_mode_ff),
      .cutoff_radius_sq (cutoff_radius_sq_ff),
      .out_valid        (fr_valid),
      .out_ctx          (fr_ctx),
      .out_sig2         (fr_sig2)
   );

   // ---- divider 1: q = (sig2 << 14) / r2, 28 quotient bits ----
   logic              q1_vld_ff [Q1W];
   ljpf_pkg::ctx_type q1_ctx_ff [Q1W];
   logic [63:0]       q1_rem_ff [Q1W];
   logic [Q1W-1:0]    q1_nl_ff  [Q1W];
   logic [Q1W-1:0]    q1_qa_ff  [Q1W];

   for (genvar k = 0; k < Q1W; k++) begin : g_q1
      logic              v_cur;
      ljpf_pkg::ctx_type c_cur;
      logic [63:0]       rem_cur, rem_in;
      logic [Q1W-1:0]    nl_cur, qa_cur;
      logic              qb;

      if (k == 0) begin : g_first
         assign v_cur   = fr_valid;
         assign c_cur   = fr_ctx;
         assign rem_cur = 64'(fr_sig2[49:14]);
         assign nl_cur  = {fr_sig2[13:0], 14'b0};
         assign qa_cur  = '0;
      end else begin : g_next
         assign v_cur   = q1_vld_ff[k-1];
         assign c_cur   = q1_ctx_ff[k-1];
         assign rem_cur = q1_rem_ff[k-1];
         assign nl_cur  = q1_nl_ff[k-1];
         assign qa_cur  = q1_qa_ff[k-1];
      end

      ljpf_div_step u_step (
         .rem_i (rem_cur),
         .bit_i (nl_cur[Q1W-1]),
         .div_i (c_cur.r2),
         .rem_o (rem_in),
         .q_o   (qb)
      );

      always_ff @(posedge clock) begin
         if (reset) begin
            q1_vld_ff[k] <= 1'b0;
         end else begin
            q1_vld_ff[k] <= v_cur;
         end
      end

      always_ff @(posedge clock) begin
         q1_ctx_ff[k] <= c_cur;
         q1_rem_ff[k] <= rem_in;
         q1_nl_ff[k]  <= {nl_cur[Q1W-2:0], 1'b0};
         q1_qa_ff[k]  <= {qa_cur[Q1W-2:0], qb};
      end
   end

   // ---- s6 and t = s6*(s6-0.5), then P = 48*eps*|t| ----
   logic [8:0]        m_vld_ff;
   ljpf_pkg::ctx_type m1_ctx_ff, m2_ctx_ff, m3_ctx_ff, m4_ctx_ff, m5_ctx_ff;
   ljpf_pkg::ctx_type m6_ctx_ff, m7_ctx_ff, m8_ctx_ff, m9_ctx_ff;
   ljpf_pkg::ctx_type m3_ctx_in, m9_ctx_in;
   logic [27:0]       m1_q_ff;
   logic [55:0]       m1_q2f_ff;
   logic [67:0]       m2_s6f_ff;
   logic [51:0]       s6;
   logic              s6_ge;
   logic [51:0]       m3_ta_ff, m3_tb_ff;
   logic [3:0][51:0]  m4_pp_ff;
   logic [103:0]      m5_tm_ff;
   logic [1:0][3:0][52:0] m6_p_ff;
   logic [1:0][130:0] m7_s_ff, m7_s_in;
   logic [157:0]      m8_p_ff;
   logic [63:0]       m9_rem_ff;
   logic [Q2W-1:0]    m9_nl_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m_vld_ff <= '0;
      end else begin
         m_vld_ff <= {m_vld_ff[7:0], q1_vld_ff[Q1W-1]};
      end
   end

   assign s6    = m2_s6f_ff[67:16];
   assign s6_ge = (s6 >= ljpf_pkg::T_HALF);

   always_comb begin
      m3_ctx_in       = m2_ctx_ff;
      m3_ctx_in.tneg  = !s6_ge && (s6 != 52'd0);
      // coefficient would reach 2^63 in Q32
      m9_ctx_in       = m8_ctx_ff;
      m9_ctx_in.huge2 = (m8_p_ff[157:127] != 31'd0) || (m8_p_ff[126:63] >= m8_ctx_ff.r2);
   end

   always_comb begin
      for (int j = 0; j < 2; j++) begin
         m7_s_in[j] = '0;
         for (int i = 0; i < 4; i++) begin
            m7_s_in[j] = m7_s_in[j] + (131'(m6_p_ff[j][i]) << (26 * i));
         end
      end
   end

   always_ff @(posedge clock) begin
      m1_ctx_ff <= q1_ctx_ff[Q1W-1];
      m1_q_ff   <= q1_qa_ff[Q1W-1];
      m1_q2f_ff <= 56'(q1_qa_ff[Q1W-1]) * 56'(q1_qa_ff[Q1W-1]);

      m2_ctx_ff <= m1_ctx_ff;
      m2_s6f_ff <= 68'(m1_q2f_ff[55:16]) * 68'(m1_q_ff);

      m3_ctx_ff <= m3_ctx_in;
      m3_ta_ff  <= s6;
      m3_tb_ff  <= s6_ge ? (s6 - ljpf_pkg::T_HALF) : (ljpf_pkg::T_HALF - s6);

      m4_ctx_ff   <= m3_ctx_ff;
      m4_pp_ff[0] <= 52'(m3_ta_ff[25:0])  * 52'(m3_tb_ff[25:0]);
      m4_pp_ff[1] <= 52'(m3_ta_ff[25:0])  * 52'(m3_tb_ff[51:26]);
      m4_pp_ff[2] <= 52'(m3_ta_ff[51:26]) * 52'(m3_tb_ff[25:0]);
      m4_pp_ff[3] <= 52'(m3_ta_ff[51:26]) * 52'(m3_tb_ff[51:26]);

      m5_ctx_ff <= m4_ctx_ff;
      m5_tm_ff  <= {m4_pp_ff[3], 52'b0} + 104'({m4_pp_ff[1], 26'b0})
                 + 104'({m4_pp_ff[2], 26'b0}) + 104'(m4_pp_ff[0]);

      m6_ctx_ff <= m5_ctx_ff;
      for (int j = 0; j < 2; j++) begin
         for (int i = 0; i < 4; i++) begin
            m6_p_ff[j][i] <= 53'(m5_tm_ff[26*i +: 26]) * 53'(m5_ctx_ff.e48[27*j +: 27]);
         end
      end

      m7_ctx_ff <= m6_ctx_ff;
      m7_s_ff   <= m7_s_in;

      m8_ctx_ff <= m7_ctx_ff;
      m8_p_ff   <= 158'(m7_s_ff[0]) + (158'(m7_s_ff[1]) << 27);

      m9_ctx_ff <= m9_ctx_in;
      m9_rem_ff <= m8_p_ff[126:63];
      m9_nl_ff  <= m8_p_ff[62:0];
   end

   // ---- divider 2: K = P / r2, 63 quotient bits ----
   logic              q2_vld_ff [Q2W];
   ljpf_pkg::ctx_type q2_ctx_ff [Q2W];
   logic [63:0]       q2_rem_ff [Q2W];
   logic [Q2W-1:0]    q2_nl_ff  [Q2W];
   logic [Q2W-1:0]    q2_qa_ff  [Q2W];

   for (genvar k = 0; k < Q2W; k++) begin : g_q2
      logic              v_cur;
      ljpf_pkg::ctx_type c_cur;
      logic [63:0]       rem_cur, rem_in;
      logic [Q2W-1:0]    nl_cur, qa_cur;
      logic              qb;

      if (k == 0) begin : g_first
         assign v_cur   = m_vld_ff[8];
         assign c_cur   = m9_ctx_ff;
         assign rem_cur = m9_rem_ff;
         assign nl_cur  = m9_nl_ff;
         assign qa_cur  = '0;
      end else begin : g_next
         assign v_cur   = q2_vld_ff[k-1];
         assign c_cur   = q2_ctx_ff[k-1];
         assign rem_cur = q2_rem_ff[k-1];
         assign nl_cur  = q2_nl_ff[k-1];
         assign qa_cur  = q2_qa_ff[k-1];
      end

      ljpf_div_step u_step (
         .rem_i (rem_cur),
         .bit_i (nl_cur[Q2W-1]),
         .div_i (c_cur.r2),
         .rem_o (rem_in),
         .q_o   (qb)
      );

      always_ff @(posedge clock) begin
         if (reset) begin
            q2_vld_ff[k] <= 1'b0;
         end else begin
            q2_vld_ff[k] <= v_cur;
         end
      end

      always_ff @(posedge clock) begin
         q2_ctx_ff[k] <= c_cur;
         q2_rem_ff[k] <= rem_in;
         q2_nl_ff[k]  <= {nl_cur[Q2W-2:0], 1'b0};
         q2_qa_ff[k]  <= {qa_cur[Q2W-2:0], qb};
      end
   end

   // ---- scale by |d|, saturate, sign ----
   logic [1:0]        e_vld_ff;
   ljpf_pkg::ctx_type e1_ctx_ff, e2_ctx_ff;
   logic [2:0][62:0]  e1_hi_ff;
   logic [2:0][63:0]  e1_lo_ff;
   logic [2:0][62:0]  e2_mag_ff;
   logic [2:0][94:0]  mag_full;
   logic [Q2W-1:0]    coef;

   logic              rsp_vld_ff;
   ljpf_pkg::rsp_type rsp_ff, rsp_in;

   logic              huge, tn;
   logic [2:0]        neg, clip;
   logic [2:0][31:0]  mag32, fv;

   assign coef = q2_qa_ff[Q2W-1];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mag_full[i] = {e1_hi_ff[i], 32'b0} + 95'(e1_lo_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_vld_ff   <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         e_vld_ff   <= {e_vld_ff[0], q2_vld_ff[Q2W-1]};
         rsp_vld_ff <= e_vld_ff[1];
      end
   end

   always_ff @(posedge clock) begin
      e1_ctx_ff <= q2_ctx_ff[Q2W-1];
      for (int i = 0; i < 3; i++) begin
         e1_hi_ff[i] <= 63'(coef[62:32]) * 63'(q2_ctx_ff[Q2W-1].dm[i]);
         e1_lo_ff[i] <= 64'(coef[31:0]) * 64'(q2_ctx_ff[Q2W-1].dm[i]);
      end
      e2_ctx_ff <= e1_ctx_ff;
      for (int i = 0; i < 3; i++) begin
         e2_mag_ff[i] <= mag_full[i][94:32];
      end
      rsp_ff <= rsp_in;
   end

   always_comb begin
      huge = e2_ctx_ff.huge1 ? e2_ctx_ff.eps_nz : e2_ctx_ff.huge2;
      tn   = !e2_ctx_ff.huge1 && e2_ctx_ff.tneg;
      for (int i = 0; i < 3; i++) begin
         neg[i]  = e2_ctx_ff.dneg[i] ^ tn;
         clip[i] = 1'b0;
         if (e2_ctx_ff.dm[i] == 32'd0) begin
            mag32[i] = '0;
         end else if (huge) begin
            mag32[i] = neg[i] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            clip[i]  = 1'b1;
         end else if (!neg[i] && e2_mag_ff[i] > 63'h7FFF_FFFF) begin
            mag32[i] = 32'h7FFF_FFFF;
            clip[i]  = 1'b1;
         end else if (neg[i] && e2_mag_ff[i] > 63'h8000_0000) begin
            mag32[i] = 32'h8000_0000;
            clip[i]  = 1'b1;
         end else begin
            mag32[i] = e2_mag_ff[i][31:0];
         end
         fv[i] = neg[i] ? (32'd0 - mag32[i]) : mag32[i];
      end

      rsp_in = '0;
      if (e2_ctx_ff.zero) begin
         rsp_in.zero_distance = 1'b1;
      end else if (e2_ctx_ff.beyond) begin
         rsp_in.beyond_cutoff = 1'b1;
      end else begin
         rsp_in.fx        = $signed(fv[0]);
         rsp_in.fy        = $signed(fv[1]);
         rsp_in.fz        = $signed(fv[2]);
         rsp_in.saturated = |clip;
      end
   end

   assign rsp_strobe = rsp_vld_ff;
   assign rsp_data   = rsp_ff;

endmodule
